### rtl/gap_halving_exchange_sort_unit_defines.svh
// Assertion macros used by the checker file of the gap-halving exchange sort unit.
// Each macro expands to one labeled concurrent assertion with an asynchronous reset disable.
`ifndef GAP_HALVING_EXCHANGE_SORT_UNIT_DEFINES_SVH
`define GAP_HALVING_EXCHANGE_SORT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GHES_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gap-halving sort unit assertion failed");

// Next-cycle implication.
`define GHES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gap-halving sort unit assertion failed");

`endif

### rtl/ghes_pkg.sv
// Shared constants, types and conversion functions of the gap-halving exchange sort unit.
// Depends on nothing; every module of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ghes_pkg;

  localparam int Depth        = 64;
  localparam int ElementWidth = 16;
  localparam int FieldWidth   = 16;
  localparam int CountW       = $clog2(Depth + 1);
  localparam int AddrW        = $clog2(Depth);
  localparam int QueueDepth   = 4;
  localparam int QPtrW        = $clog2(QueueDepth);

  typedef logic signed [ElementWidth-1:0] elem_t;
  typedef logic [CountW-1:0]              count_t;
  typedef logic [AddrW-1:0]               addr_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] element;
    logic                         final_element;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] sorted_value;
    logic                         final_result;
  } out_item_t;

  // One classified item on its way from the front end to the sort engine.
  typedef struct packed {
    elem_t element;
    logic  store;
    logic  final_mark;
  } q_entry_t;

  function automatic elem_t to_elem(input logic signed [FieldWidth-1:0] x);
    logic signed [63:0] ext;
    begin
      ext = 64'(x);
      return ext[ElementWidth-1:0];
    end
  endfunction

  function automatic logic signed [FieldWidth-1:0] from_elem(input elem_t e);
    logic signed [63:0] ext;
    begin
      ext = 64'(e);
      return ext[FieldWidth-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/gap_halving_exchange_sort_unit.sv
// Gap-halving exchange sort unit. Elements load only in the load state and wait in the
// queue while a set sorts or drains. The buffer memory has two read ports: a compare
// reads a pair (SRd), compares it (SCmp) and on a swap writes both back (SCmp, SWr2); a
// pass at gap g makes n-g compares. Results leave via SEmRd, SEmOut and wait until popped.
// Reset is asynchronous and active low; it clears counts and control, not the buffer.
`timescale 1ns / 1ps
`default_nettype none

module gap_halving_exchange_sort_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire ghes_pkg::in_item_t in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output ghes_pkg::out_item_t     out_item_o
);

  logic q_push, q_full, q_pop, q_valid;
  ghes_pkg::q_entry_t q_entry_in, q_entry_out;

  ghes_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry_in),
    .q_full_i  (q_full)
  );

  ghes_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_entry_out),
    .valid_o (q_valid)
  );

  ghes_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry_out),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

### rtl/ghes_queue.sv
// Short first-in first-out queue between the front end and the sort engine.
// Uses ghes_pkg for the entry type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module ghes_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ghes_pkg::q_entry_t entry_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output ghes_pkg::q_entry_t      entry_o,
  output logic                    valid_o
);

  ghes_pkg::q_entry_t entries_q [ghes_pkg::QueueDepth];
  logic [ghes_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ghes_pkg::QPtrW:0]   fill_q, fill_d;
  logic do_push, do_pop;

  assign full_o  = (fill_q == (ghes_pkg::QPtrW+1)'(ghes_pkg::QueueDepth));
  assign valid_o = (fill_q != '0);
  assign entry_o = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/ghes_front.sv
// Front end: takes input transfers, decides whether each element is kept or dropped,
// and forwards kept elements and set-closing items to the queue. Uses ghes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghes_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ghes_pkg::in_item_t in_item_i,
  output logic                    full_o,
  output logic                    q_push_o,
  output ghes_pkg::q_entry_t      q_entry_o,
  input  wire logic               q_full_i
);

  ghes_pkg::count_t count_q, count_d;
  logic accept, store;

  assign full_o  = q_full_i;
  assign accept  = push_i && !q_full_i;
  assign store   = (count_q < ghes_pkg::count_t'(ghes_pkg::Depth));

  // A dropped element that does not close the set leaves nothing for the engine.
  assign q_push_o             = accept && (store || in_item_i.final_element);
  assign q_entry_o.element    = ghes_pkg::to_elem(in_item_i.element);
  assign q_entry_o.store      = store;
  assign q_entry_o.final_mark = in_item_i.final_element;

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (in_item_i.final_element) begin
        count_d = '0;
      end else if (store) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ghes_back.sv
// Sort engine: loads queued elements into a local buffer memory, runs the gap-halving
// exchange passes, then drives the sorted elements into the result register. Uses ghes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghes_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire ghes_pkg::q_entry_t q_entry_i,
  output logic                    q_pop_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output ghes_pkg::out_item_t     out_item_o
);

  localparam logic [2:0] SLoad  = 3'd0;
  localparam logic [2:0] SRd    = 3'd1;
  localparam logic [2:0] SCmp   = 3'd2;
  localparam logic [2:0] SWr2   = 3'd3;
  localparam logic [2:0] SEmRd  = 3'd4;
  localparam logic [2:0] SEmOut = 3'd5;

  logic [2:0] state_q, state_d;
  ghes_pkg::count_t cnt_q, cnt_d, n_q, n_d;
  ghes_pkg::addr_t  gap_q, gap_d, idx_q, idx_d, k_q, k_d;
  logic swapped_q, swapped_d, swapped_now;
  logic out_valid_q, out_valid_d;
  ghes_pkg::out_item_t out_q, out_d;

  ghes_pkg::elem_t mem [ghes_pkg::Depth];
  ghes_pkg::elem_t rd_a_q, rd_b_q, wd;
  ghes_pkg::addr_t ra, idx_b, wa;
  logic we, advance;

  ghes_pkg::count_t n_load, half_load, nxt, end_sum;
  ghes_pkg::addr_t  gap_half;

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  assign idx_b     = idx_q + gap_q;
  assign ra        = ((state_q == SEmRd) || (state_q == SEmOut)) ? k_q : idx_q;
  assign n_load    = cnt_q + ghes_pkg::count_t'(q_entry_i.store);
  assign half_load = n_load >> 1;
  assign nxt       = ghes_pkg::count_t'(idx_q) + 1'b1;
  assign end_sum   = nxt + ghes_pkg::count_t'(gap_q);
  assign gap_half  = gap_q >> 1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    gap_d       = gap_q;
    idx_d       = idx_q;
    k_d         = k_q;
    swapped_d   = swapped_q;
    swapped_now = swapped_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    we          = 1'b0;
    wa          = idx_q;
    wd          = rd_b_q;
    q_pop_o     = 1'b0;
    advance     = 1'b0;

    case (state_q)
      SLoad: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          if (q_entry_i.store) begin
            we    = 1'b1;
            wa    = cnt_q[ghes_pkg::AddrW-1:0];
            wd    = q_entry_i.element;
            cnt_d = cnt_q + 1'b1;
          end
          if (q_entry_i.final_mark) begin
            n_d       = n_load;
            cnt_d     = '0;
            gap_d     = half_load[ghes_pkg::AddrW-1:0];
            idx_d     = '0;
            k_d       = '0;
            swapped_d = 1'b0;
            // A single element needs no pass and goes straight to output.
            state_d   = (half_load == '0) ? SEmRd : SRd;
          end
        end
      end
      SRd: begin
        state_d = SCmp;
      end
      SCmp: begin
        if (rd_a_q > rd_b_q) begin
          we        = 1'b1;
          wa        = idx_q;
          wd        = rd_b_q;
          swapped_d = 1'b1;
          state_d   = SWr2;
        end else begin
          advance = 1'b1;
        end
      end
      SWr2: begin
        // The read register still holds the lower-index element from before the first write.
        we          = 1'b1;
        wa          = idx_b;
        wd          = rd_a_q;
        swapped_now = 1'b1;
        advance     = 1'b1;
      end
      SEmRd: begin
        state_d = SEmOut;
      end
      SEmOut: begin
        if (!out_valid_q || pop_i) begin
          out_valid_d        = 1'b1;
          out_d.sorted_value = ghes_pkg::from_elem(rd_a_q);
          out_d.final_result = (ghes_pkg::count_t'(k_q) + 1'b1 == n_q);
          if (out_d.final_result) begin
            state_d = SLoad;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = SEmRd;
          end
        end
      end
      default: begin
        state_d = SLoad;
      end
    endcase

    if (advance) begin
      if (end_sum < n_q) begin
        idx_d   = nxt[ghes_pkg::AddrW-1:0];
        state_d = SRd;
      end else if (swapped_now) begin
        idx_d     = '0;
        swapped_d = 1'b0;
        state_d   = SRd;
      end else if (gap_half == '0) begin
        k_d     = '0;
        state_d = SEmRd;
      end else begin
        gap_d     = gap_half;
        idx_d     = '0;
        swapped_d = 1'b0;
        state_d   = SRd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SLoad;
      cnt_q       <= '0;
      n_q         <= '0;
      gap_q       <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      swapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      gap_q       <= gap_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      swapped_q   <= swapped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Element buffer: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[idx_b];
  end

endmodule

`default_nettype wire

### rtl/ghes_checker.sv
// Port-level checker for the gap-halving exchange sort unit, bound to the top level.
// Uses ghes_pkg and the assertion macros of gap_halving_exchange_sort_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "gap_halving_exchange_sort_unit_defines.svh"

module ghes_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire ghes_pkg::out_item_t  out_item_o
);

  logic signed [ghes_pkg::FieldWidth-1:0] last_q;
  logic in_set_q;
  ghes_pkg::count_t res_cnt_q;
  logic take;

  assign take = pop && !empty;

  // Track the previous result transfer of the current set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      in_set_q  <= 1'b0;
      res_cnt_q <= '0;
    end else if (take) begin
      last_q    <= out_item_o.sorted_value;
      in_set_q  <= !out_item_o.final_result;
      res_cnt_q <= out_item_o.final_result ? '0 : res_cnt_q + 1'b1;
    end
  end

  `GHES_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))
  `GHES_ASSERT_SAME(a_ascending, clk_i, rst_ni, take && in_set_q, out_item_o.sorted_value >= last_q)
  `GHES_ASSERT_SAME(a_set_size, clk_i, rst_ni, take, res_cnt_q < ghes_pkg::count_t'(ghes_pkg::Depth))

endmodule

bind gap_halving_exchange_sort_unit ghes_checker u_ghes_checker (.*);

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the gap-halving exchange sort unit: sends sets of signed
// elements through the push side and checks every popped result against a scoreboard.
// Depends on ghes_pkg for the item types and on the gap_halving_exchange_sort_unit RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int          RandomItems = 290;
  localparam int          QuietFrom   = 240;
  localparam int          MaxReported = 10;

  typedef enum int {STYLE_WIDE, STYLE_CLUSTERED, STYLE_EDGES} value_style_e;
  typedef ghes_pkg::elem_t elem_q_t[$];

  // Keeps the set being collected and the sorted results that are still owed.
  class sort_scoreboard;
    ghes_pkg::elem_t     held[$];
    ghes_pkg::out_item_t owed[$];
    int                  mismatches;
    int                  checked;
    int                  accepted;
    int                  dropped;
    int                  sets;

    function void sort_held();
      int              n;
      int              gap;
      int              i;
      bit              swapped;
      ghes_pkg::elem_t tmp;
      n = held.size();
      for (gap = n / 2; gap > 0; gap = gap / 2) begin
        do begin
          swapped = 1'b0;
          for (i = 0; i + gap < n; i++) begin
            if (held[i] > held[i + gap]) begin
              tmp           = held[i];
              held[i]       = held[i + gap];
              held[i + gap] = tmp;
              swapped       = 1'b1;
            end
          end
        end while (swapped);
      end
    endfunction

    function void note_input(ghes_pkg::in_item_t it);
      ghes_pkg::out_item_t r;
      accepted++;
      // A full buffer drops the element, but a final mark still closes the set.
      if (held.size() < ghes_pkg::Depth) begin
        held.push_back(it.element);
      end else begin
        dropped++;
      end
      if (it.final_element) begin
        sort_held();
        foreach (held[k]) begin
          r.sorted_value = held[k];
          r.final_result = (k == held.size() - 1);
          owed.push_back(r);
        end
        held.delete();
        sets++;
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MaxReported) begin
        $display("[%0t] MISMATCH: %s", $realtime, what);
      end
    endfunction

    function void check_result(ghes_pkg::out_item_t got);
      ghes_pkg::out_item_t want;
      checked++;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result value=%0d final=%0b",
                       got.sorted_value, got.final_result));
        return;
      end
      want = owed.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        flag($sformatf("sorted_value expected %0d actual %0d",
                       want.sorted_value, got.sorted_value));
      end
      if (got.final_result !== want.final_result) begin
        flag($sformatf("final_result expected %0b actual %0b (value %0d)",
                       want.final_result, got.final_result, want.sorted_value));
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                push    = 1'b0;
  logic                pop     = 1'b0;
  ghes_pkg::in_item_t  in_item = '0;
  logic                full;
  logic                empty;
  ghes_pkg::out_item_t out_item;

  sort_scoreboard sb = new();
  bit             quiet = 1'b0;
  int unsigned    cycles = 0;
  int             random_items = 0;

  gap_halving_exchange_sort_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // One element per transfer; push stays high between back-to-back transfers.
  task automatic send_item(input ghes_pkg::elem_t value, input logic last);
    ghes_pkg::in_item_t it;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    it.element       = value;
    it.final_element = last;
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_input(it);
  endtask

  task automatic send_set(input elem_q_t vals);
    foreach (vals[k]) begin
      send_item(vals[k], k == vals.size() - 1);
    end
  endtask

  function automatic ghes_pkg::elem_t pick_element(input value_style_e style);
    case (style)
      STYLE_WIDE:      return ghes_pkg::elem_t'($urandom);
      STYLE_CLUSTERED: return ghes_pkg::elem_t'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return ghes_pkg::elem_t'(int'($urandom_range(0, 2)) - 1);
          default: return ghes_pkg::elem_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Result side: pop stalls in random bursts until the quiet tail of the run.
  initial begin
    wait (rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) sb.check_result(out_item);
    end
  end

  initial begin
    elem_q_t      vals;
    int           set_no;
    int           size;
    int           pick;
    value_style_e style;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets: lone element, reversed pair, extremes with duplicates,
    // all-equal elements, already ascending and strictly descending.
    send_set('{16'sh7fff});
    send_set('{16'sh7fff, 16'sh8000});
    send_set('{16'sh0000, -16'sd1, 16'sd1, 16'sh8000, 16'sh7fff, -16'sd1, 16'sh0000});
    send_set('{16'sd5, 16'sd5, 16'sd5, 16'sd5});
    send_set('{-16'sd3, -16'sd2, -16'sd1, 16'sd0, 16'sd1, 16'sd2});
    send_set('{16'sd100, 16'sd50, 16'sd0, -16'sd50, -16'sd100});

    // Random sets, mostly short; the first two overflow and exactly fill the buffer.
    set_no = 0;
    while (random_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (set_no == 0 || pick >= 95)      size = ghes_pkg::Depth + $urandom_range(1, 4);
      else if (set_no == 1 || pick >= 90) size = ghes_pkg::Depth;
      else if (pick >= 80)                size = $urandom_range(11, 40);
      else                                size = $urandom_range(1, 10);
      style = value_style_e'($urandom_range(0, 2));
      vals.delete();
      repeat (size) vals.push_back(pick_element(style));
      if (random_items >= QuietFrom) quiet = 1'b1;
      send_set(vals);
      random_items += size;
      set_no++;
    end
    quiet = 1'b1;
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d sets from %0d accepted elements (%0d dropped on a full buffer).",
             sb.sets, sb.accepted, sb.dropped);
    $display("Checked %0d sorted results, %0d mismatches, %0d results still owed.",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
